@@ rtl/wam_pkg.sv @@
`default_nettype none

package wam_pkg;

  localparam int unsigned OpW  = 64;
  localparam int unsigned AccW = 2 * OpW;

  // Iterations per command: shift-add steps for multiply, restoring steps for divide.
  localparam int unsigned MulSteps = OpW;
  localparam int unsigned DivSteps = AccW;
  localparam int unsigned CntW     = $clog2(DivSteps);

  localparam logic [CntW-1:0] MulLast = CntW'(MulSteps - 1);
  localparam logic [CntW-1:0] DivLast = CntW'(DivSteps - 1);

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_MUL  = 2'd1,
    CMD_DIV  = 2'd2,
    CMD_CMP  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e           command;
    logic [OpW-1:0] operand;
  } in_t;

  typedef struct packed {
    logic [OpW-1:0] quotient;
    logic [OpW-1:0] remainder;
    logic [OpW-1:0] low_word;
    logic           is_greater;
    logic           divide_error;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic start;
    logic step;
    logic publish;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    cmd_e command;
    logic iterate;
  } stat_t;

endpackage

`default_nettype wire

@@ rtl/wide_accumulator_mul_div.sv @@
`default_nettype none

// Channel  Dir  Handshake                  Payload
// in       in   in_valid_i / in_stall_o    wam_pkg::in_t  {command, operand}
// out      out  out_valid_o / out_stall_i  wam_pkg::out_t {quotient, remainder,
//                                          low_word, is_greater, divide_error}
//
// One item at a time. Load and compare run no steps; multiply runs 64 shift-add
// steps of a 128-bit adder, divide 128 restoring steps of a 66-bit subtractor;
// a zero divisor skips the steps.
// rst_ni clears the accumulator to zero. A finished result sits in the output
// register; while it is stalled, the next item waits in the finish state.

module wide_accumulator_mul_div (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire wam_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output wam_pkg::out_t      out_data_o
);

  wam_pkg::ctl_t  ctl;
  wam_pkg::stat_t stat;

  wam_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .ctl_o       (ctl)
  );

  wam_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .in_data_i  (in_data_i),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

@@ rtl/wam_ctrl.sv @@
`default_nettype none

module wam_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  input  wire wam_pkg::stat_t stat_i,
  output wam_pkg::ctl_t       ctl_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_e;

  state_e                    state_q;
  logic [wam_pkg::CntW-1:0]  cnt_q;
  logic                      out_valid_q;
  logic                      out_free;
  logic [wam_pkg::CntW-1:0]  last;

  assign out_free = !out_valid_q || !out_stall_i;
  assign last     = (stat_i.command == wam_pkg::CMD_MUL) ? wam_pkg::MulLast : wam_pkg::DivLast;

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign ctl_o.start   = in_valid_i && (state_q == ST_IDLE);
  assign ctl_o.step    = (state_q == ST_RUN) && stat_i.iterate;
  assign ctl_o.publish = (state_q == ST_FINISH) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (ctl_o.start) begin
            state_q <= ST_RUN;
            cnt_q   <= '0;
          end
        end
        ST_RUN: begin
          if (!stat_i.iterate || cnt_q == last) begin
            state_q <= ST_FINISH;
          end else begin
            cnt_q <= wam_pkg::CntW'(cnt_q + 1'b1);
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      if (ctl_o.publish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/wam_dp.sv @@
`default_nettype none

module wam_dp (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire wam_pkg::ctl_t ctl_i,
  input  wire wam_pkg::in_t  in_data_i,
  output wam_pkg::stat_t     stat_o,
  output wam_pkg::out_t      out_data_o
);

  localparam int unsigned OpW  = wam_pkg::OpW;
  localparam int unsigned AccW = wam_pkg::AccW;

  wam_pkg::cmd_e   cmd_q;
  logic [OpW-1:0]  op_q;      // divisor/comparand; shifted right as multiplier
  logic [AccW-1:0] acc_q;
  logic [AccW-1:0] work_q;    // multiplicand, or dividend turning into quotient
  logic [AccW-1:0] prod_q;
  logic [OpW-1:0]  rem_q;
  wam_pkg::out_t   out_q;

  logic            is_div_ok;
  logic            div_zero;
  logic [OpW:0]    cand;
  logic [OpW+1:0]  diff;
  logic            ge;
  logic [AccW-1:0] acc_next;
  wam_pkg::out_t   res;

  assign div_zero  = (op_q == '0);
  assign is_div_ok = (cmd_q == wam_pkg::CMD_DIV) && !div_zero;

  assign stat_o.command = cmd_q;
  assign stat_o.iterate = (cmd_q == wam_pkg::CMD_MUL) || is_div_ok;

  // restoring step: 65-bit partial remainder against the divisor
  assign cand = {rem_q, work_q[AccW-1]};
  assign diff = {1'b0, cand} - {2'b00, op_q};
  assign ge   = !diff[OpW+1];

  always_comb begin
    case (cmd_q)
      wam_pkg::CMD_LOAD: acc_next = {{OpW{1'b0}}, op_q};
      wam_pkg::CMD_MUL:  acc_next = prod_q;
      default:           acc_next = acc_q;
    endcase
    res.quotient     = is_div_ok ? work_q[OpW-1:0] : '0;
    res.remainder    = is_div_ok ? rem_q : '0;
    res.low_word     = acc_next[OpW-1:0];
    res.is_greater   = (cmd_q == wam_pkg::CMD_CMP) &&
                       ((acc_q[AccW-1:OpW] != '0) || (acc_q[OpW-1:0] > op_q));
    res.divide_error = (cmd_q == wam_pkg::CMD_DIV) && div_zero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctl_i.publish) begin
      acc_q <= acc_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      cmd_q  <= in_data_i.command;
      op_q   <= in_data_i.operand;
      work_q <= acc_q;
      prod_q <= '0;
      rem_q  <= '0;
    end else if (ctl_i.step) begin
      if (cmd_q == wam_pkg::CMD_MUL) begin
        if (op_q[0]) begin
          prod_q <= prod_q + work_q;
        end
        work_q <= {work_q[AccW-2:0], 1'b0};
        op_q   <= {1'b0, op_q[OpW-1:1]};
      end else begin
        rem_q  <= ge ? diff[OpW-1:0] : cand[OpW-1:0];
        work_q <= {work_q[AccW-2:0], ge};
      end
    end
    if (ctl_i.publish) begin
      out_q <= res;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

@@ rtl/wam_checker.sv @@
`default_nettype none

module wam_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_stall_o,
  input wire logic          out_valid_o,
  input wire logic          out_stall_i,
  input wire wam_pkg::out_t out_data_o
);

  // single item in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("item accepted while previous item in flight");

  a_div_err_zeros: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.divide_error) |->
      (out_data_o.quotient == '0 && out_data_o.remainder == '0))
    else $error("divide error with nonzero quotient or remainder");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.is_greater && out_data_o.divide_error))
    else $error("compare and divide flags both set");

  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

endmodule

bind wide_accumulator_mul_div wam_checker u_wam_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
